### src/traffic_rate_average_peak_monitor_macros.svh
// ---------------------------------------------------------------------------
// Traffic rate monitor assertion macros
// Shorthand for the clocked, reset-gated checks used by the monitor.
// ---------------------------------------------------------------------------
`ifndef TRAFFIC_RATE_AVERAGE_PEAK_MONITOR_MACROS_SVH
`define TRAFFIC_RATE_AVERAGE_PEAK_MONITOR_MACROS_SVH

// Same-cycle implication.
`define TRAPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TRAPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/trapm_pkg.sv
// ---------------------------------------------------------------------------
// Traffic rate monitor package
// Field widths, beat types and sequencer states shared by the monitor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package trapm_pkg;

    localparam int TOTAL_W    = 63;
    localparam int RATE_W     = 32;
    localparam int FIX_W      = 40;
    localparam int FRAC_W     = 8;
    localparam int WIN_W      = 13;
    localparam int SUM_W      = RATE_W + WIN_W;
    localparam int DIVIDEND_W = SUM_W + FRAC_W;

    localparam logic [WIN_W-1:0]  WINDOW_RESET = 13'd30;
    localparam logic [RATE_W-1:0] RATE_MAX     = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [TOTAL_W-1:0] received_total_bytes;
        logic [TOTAL_W-1:0] sent_total_bytes;
    } in_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] received_total_echo;
        logic [TOTAL_W-1:0] sent_total_echo;
        logic [FIX_W-1:0]   received_average;
        logic [FIX_W-1:0]   sent_average;
        logic [FIX_W-1:0]   received_peak;
        logic [FIX_W-1:0]   sent_peak;
        logic               baseline_only;
    } out_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DELTA,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_DIV_RX_GO,
        ST_DIV_RX_WAIT,
        ST_DIV_TX_GO,
        ST_DIV_TX_WAIT,
        ST_SM_WR,
        ST_PEAK_RD,
        ST_PEAK_CMP,
        ST_DONE,
        ST_RB_INIT,
        ST_RB_ENTRY,
        ST_RB_SUB_RD,
        ST_RB_SUB,
        ST_RB_ADD_RD,
        ST_RB_ADD
    } state_t;

endpackage

### src/trapm_div.sv
// ---------------------------------------------------------------------------
// Traffic rate monitor divider
// Restoring divider, one quotient bit per cycle, shared by both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module trapm_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [trapm_pkg::DIVIDEND_W-1:0]      dividend,
    input  logic [trapm_pkg::WIN_W-1:0]           divisor,
    output logic                                  done,
    output logic [trapm_pkg::DIVIDEND_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(trapm_pkg::DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(trapm_pkg::DIVIDEND_W - 1);

    logic                                 run_reg, run_next;
    logic                                 done_reg, done_next;
    logic [CNT_W-1:0]                     cnt_reg, cnt_next;
    logic [trapm_pkg::WIN_W-1:0]          rem_reg, rem_next;
    logic [trapm_pkg::DIVIDEND_W-1:0]     quo_reg, quo_next;
    logic [trapm_pkg::WIN_W-1:0]          div_reg, div_next;
    logic [trapm_pkg::WIN_W:0]            trial;
    logic [trapm_pkg::WIN_W:0]            diff;
    logic                                 fits;

    // Shift the next dividend bit into the partial remainder.
    assign trial = {rem_reg, quo_reg[trapm_pkg::DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dividend;
            div_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[trapm_pkg::WIN_W-1:0] : trial[trapm_pkg::WIN_W-1:0];
            quo_next = {quo_reg[trapm_pkg::DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_BIT)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### src/traffic_rate_average_peak_monitor.sv
// ---------------------------------------------------------------------------
// Traffic rate average and peak monitor
// Moving average and windowed peak of per-tick byte deltas for two channels.
// ---------------------------------------------------------------------------
// Usage: present one beat of cumulative received/sent byte totals per sample
// tick on in_valid/in_ready; one result beat leaves on out_valid/out_ready.
// The first beat after reset only sets the baseline and returns a result
// beat with baseline_only high. A later beat makes one pass over the
// N = min(count, window) newest rate memory entries, two runs of the shared
// bit-serial divider, and one pass over the smoothed memories covering the
// L = min(count, LOOKBACK_FACTOR*window) newest entries. in_ready is low
// while a beat is in work.
// A finished result sits in the output register; if the receiver stalls, the
// next beat is still taken and held at the end of its work until the output
// register frees up.
// cfg_wr_en writes window_length (clamped to 1..HISTORY_DEPTH); a changed
// value rebuilds the smoothed history with in_ready low. Reset clears the
// baseline and history count; the history memories need no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module traffic_rate_average_peak_monitor #(
    parameter int HISTORY_DEPTH   = 4096,
    parameter int LOOKBACK_FACTOR = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  trapm_pkg::in_t                in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output trapm_pkg::out_t               out_data,
    input  logic                          cfg_wr_en,
    input  logic [trapm_pkg::WIN_W-1:0]   cfg_wr_data
);

    localparam int AW  = $clog2(HISTORY_DEPTH);
    localparam int CW  = $clog2(HISTORY_DEPTH + 1);
    localparam int XW  = ((CW > trapm_pkg::WIN_W) ? CW : trapm_pkg::WIN_W) + 1;
    localparam int LFW = $clog2(LOOKBACK_FACTOR + 1);
    localparam int LKW = trapm_pkg::WIN_W + LFW;
    localparam int MW  = (LKW > XW) ? LKW : XW;
    localparam int RW  = trapm_pkg::RATE_W;
    localparam int FW  = trapm_pkg::FIX_W;
    localparam int SW  = trapm_pkg::SUM_W;
    localparam int TW  = trapm_pkg::TOTAL_W;
    localparam int WW  = trapm_pkg::WIN_W;

    localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C   = CW'(HISTORY_DEPTH);
    localparam logic [XW-1:0] DEPTH_X   = XW'(HISTORY_DEPTH);
    localparam logic [MW-1:0] LOOK_MUL  = MW'(LOOKBACK_FACTOR);

    function automatic logic [trapm_pkg::RATE_W-1:0] rate_delta(
        input logic [trapm_pkg::TOTAL_W-1:0] cur,
        input logic [trapm_pkg::TOTAL_W-1:0] prev
    );
        logic [trapm_pkg::TOTAL_W-1:0] d;
        d = cur - prev;
        if (cur < prev)
            return '0;
        else if (|d[trapm_pkg::TOTAL_W-1:trapm_pkg::RATE_W])
            return trapm_pkg::RATE_MAX;
        else
            return d[trapm_pkg::RATE_W-1:0];
    endfunction

    trapm_pkg::state_t state_reg, state_next;

    logic              rb_mode_reg, rb_mode_next;
    logic [WW-1:0]     window_reg, window_next;
    logic              have_base_reg, have_base_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     newest_reg, newest_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     rb_i_reg, rb_i_next;
    logic              out_valid_reg, out_valid_next;

    logic [TW-1:0]     prev_rx_reg, prev_rx_next;
    logic [TW-1:0]     prev_tx_reg, prev_tx_next;
    trapm_pkg::in_t    in_reg, in_next;
    logic              base_flag_reg, base_flag_next;
    logic [SW-1:0]     sum_rx_reg, sum_rx_next;
    logic [SW-1:0]     sum_tx_reg, sum_tx_next;
    logic [WW-1:0]     div_n_reg, div_n_next;
    logic [FW-1:0]     avg_rx_reg, avg_rx_next;
    logic [FW-1:0]     avg_tx_reg, avg_tx_next;
    logic [FW-1:0]     best_rx_reg, best_rx_next;
    logic [FW-1:0]     best_tx_reg, best_tx_next;
    trapm_pkg::out_t   out_reg, out_next;

    logic [RW-1:0]     rate_rx_mem [HISTORY_DEPTH];
    logic [RW-1:0]     rate_tx_mem [HISTORY_DEPTH];
    logic [FW-1:0]     sm_rx_mem   [HISTORY_DEPTH];
    logic [FW-1:0]     sm_tx_mem   [HISTORY_DEPTH];
    logic [RW-1:0]     rate_rx_rd_reg, rate_tx_rd_reg;
    logic [FW-1:0]     sm_rx_rd_reg, sm_tx_rd_reg;

    logic              in_fire;
    logic              rate_we, sm_we;
    logic [AW-1:0]     newest_inc;
    logic [AW-1:0]     sm_wr_slot;
    logic [RW-1:0]     delta_rx, delta_tx;
    logic [XW-1:0]     win_x, cnt_x, eff_x, left_x, rb_n_x, add_age_x, newest_x;
    logic [XW-1:0]     rd_age_x, rd_slot_x;
    logic [WW-1:0]     eff, rb_n;
    logic [MW-1:0]     look_m, cnt_m, look_c;
    logic [CW-1:0]     look;
    logic [CW-1:0]     rd_age;
    logic [AW-1:0]     rd_slot;
    logic              rb_has_add;
    logic [WW-1:0]     cfg_win;
    logic [XW-1:0]     cfg_x;
    logic              cfg_change;

    logic                                 div_start;
    logic                                 div_done;
    logic [trapm_pkg::DIVIDEND_W-1:0]     div_dividend;
    logic [trapm_pkg::DIVIDEND_W-1:0]     div_quotient;

    trapm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_n_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign in_ready = (state_reg == trapm_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    // Window lengths, counts and ages.
    assign win_x  = XW'(window_reg);
    assign cnt_x  = XW'(count_reg);
    assign eff_x  = (win_x < cnt_x) ? win_x : cnt_x;
    assign eff    = eff_x[WW-1:0];
    assign left_x = cnt_x - XW'(rb_i_reg);
    assign rb_n_x = (eff_x < left_x) ? eff_x : left_x;
    assign rb_n   = rb_n_x[WW-1:0];

    assign add_age_x  = XW'(rb_i_reg) + eff_x;
    assign rb_has_add = add_age_x < cnt_x;

    assign look_m = MW'(window_reg) * LOOK_MUL;
    assign cnt_m  = MW'(count_reg);
    assign look_c = (look_m < cnt_m) ? look_m : cnt_m;
    assign look   = look_c[CW-1:0];

    assign newest_inc = (newest_reg == LAST_SLOT) ? '0 : newest_reg + 1'b1;

    always_comb
    begin
        case (state_reg)
            trapm_pkg::ST_RB_ADD_RD:                     rd_age = add_age_x[CW-1:0];
            trapm_pkg::ST_RB_SUB_RD, trapm_pkg::ST_SM_WR: rd_age = rb_i_reg;
            default:                                     rd_age = idx_reg;
        endcase
    end

    // Age to slot, newest entry is age zero.
    assign rd_age_x  = XW'(rd_age);
    assign newest_x  = XW'(newest_reg);
    assign rd_slot_x = (newest_x >= rd_age_x) ? (newest_x - rd_age_x)
                                              : (newest_x + DEPTH_X - rd_age_x);
    assign rd_slot   = rd_slot_x[AW-1:0];

    assign sm_wr_slot = rb_mode_reg ? rd_slot : newest_reg;

    assign delta_rx = rate_delta(in_reg.received_total_bytes, prev_rx_reg);
    assign delta_tx = rate_delta(in_reg.sent_total_bytes, prev_tx_reg);

    // Clamp the written window to 1..HISTORY_DEPTH.
    assign cfg_x = XW'(cfg_wr_data);
    always_comb
    begin
        if (cfg_wr_data == '0)
            cfg_win = WW'(1);
        else if (cfg_x > DEPTH_X)
            cfg_win = DEPTH_X[WW-1:0];
        else
            cfg_win = cfg_wr_data;
    end
    assign cfg_change = cfg_wr_en && (cfg_win != window_reg);

    assign div_dividend = (state_reg == trapm_pkg::ST_DIV_TX_GO)
                        ? {sum_tx_reg, trapm_pkg::FRAC_W'(0)}
                        : {sum_rx_reg, trapm_pkg::FRAC_W'(0)};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            trapm_pkg::ST_IDLE:
                if (in_fire)
                    state_next = have_base_reg ? trapm_pkg::ST_DELTA : trapm_pkg::ST_DONE;
            trapm_pkg::ST_DELTA:
                state_next = trapm_pkg::ST_SUM_RD;
            trapm_pkg::ST_SUM_RD:
                if (XW'(idx_reg) < eff_x)
                    state_next = trapm_pkg::ST_SUM_ACC;
                else if (rb_mode_reg)
                    state_next = trapm_pkg::ST_RB_ENTRY;
                else
                    state_next = trapm_pkg::ST_DIV_RX_GO;
            trapm_pkg::ST_SUM_ACC:
                state_next = trapm_pkg::ST_SUM_RD;
            trapm_pkg::ST_DIV_RX_GO:
                state_next = trapm_pkg::ST_DIV_RX_WAIT;
            trapm_pkg::ST_DIV_RX_WAIT:
                if (div_done)
                    state_next = trapm_pkg::ST_DIV_TX_GO;
            trapm_pkg::ST_DIV_TX_GO:
                state_next = trapm_pkg::ST_DIV_TX_WAIT;
            trapm_pkg::ST_DIV_TX_WAIT:
                if (div_done)
                    state_next = trapm_pkg::ST_SM_WR;
            trapm_pkg::ST_SM_WR:
                state_next = rb_mode_reg ? trapm_pkg::ST_RB_SUB_RD : trapm_pkg::ST_PEAK_RD;
            trapm_pkg::ST_PEAK_RD:
                state_next = (idx_reg < look) ? trapm_pkg::ST_PEAK_CMP : trapm_pkg::ST_DONE;
            trapm_pkg::ST_PEAK_CMP:
                state_next = trapm_pkg::ST_PEAK_RD;
            trapm_pkg::ST_DONE:
                if (!out_valid_reg || out_ready)
                    state_next = trapm_pkg::ST_IDLE;
            trapm_pkg::ST_RB_INIT:
                state_next = trapm_pkg::ST_SUM_RD;
            trapm_pkg::ST_RB_ENTRY:
                state_next = (rb_i_reg < count_reg) ? trapm_pkg::ST_DIV_RX_GO
                                                    : trapm_pkg::ST_IDLE;
            trapm_pkg::ST_RB_SUB_RD:
                state_next = trapm_pkg::ST_RB_SUB;
            trapm_pkg::ST_RB_SUB:
                state_next = trapm_pkg::ST_RB_ADD_RD;
            trapm_pkg::ST_RB_ADD_RD:
                state_next = rb_has_add ? trapm_pkg::ST_RB_ADD : trapm_pkg::ST_RB_ENTRY;
            trapm_pkg::ST_RB_ADD:
                state_next = trapm_pkg::ST_RB_ENTRY;
            default:
                state_next = trapm_pkg::ST_IDLE;
        endcase
        // A changed window restarts the rebuild from the retained deltas.
        if (cfg_change)
            state_next = trapm_pkg::ST_RB_INIT;
    end

    // Datapath and outputs.
    always_comb
    begin
        rb_mode_next   = rb_mode_reg;
        window_next    = window_reg;
        have_base_next = have_base_reg;
        count_next     = count_reg;
        newest_next    = newest_reg;
        idx_next       = idx_reg;
        rb_i_next      = rb_i_reg;
        out_valid_next = out_valid_reg && !out_ready;
        prev_rx_next   = prev_rx_reg;
        prev_tx_next   = prev_tx_reg;
        in_next        = in_reg;
        base_flag_next = base_flag_reg;
        sum_rx_next    = sum_rx_reg;
        sum_tx_next    = sum_tx_reg;
        div_n_next     = div_n_reg;
        avg_rx_next    = avg_rx_reg;
        avg_tx_next    = avg_tx_reg;
        best_rx_next   = best_rx_reg;
        best_tx_next   = best_tx_reg;
        out_next       = out_reg;
        rate_we        = 1'b0;
        sm_we          = 1'b0;
        div_start      = 1'b0;

        unique case (state_reg)
            trapm_pkg::ST_IDLE:
                if (in_fire)
                begin
                    in_next        = in_data;
                    base_flag_next = !have_base_reg;
                    rb_mode_next   = 1'b0;
                    avg_rx_next    = '0;
                    avg_tx_next    = '0;
                    best_rx_next   = '0;
                    best_tx_next   = '0;
                    if (!have_base_reg)
                    begin
                        have_base_next = 1'b1;
                        prev_rx_next   = in_data.received_total_bytes;
                        prev_tx_next   = in_data.sent_total_bytes;
                    end
                end
            trapm_pkg::ST_DELTA:
            begin
                rate_we      = 1'b1;
                newest_next  = newest_inc;
                prev_rx_next = in_reg.received_total_bytes;
                prev_tx_next = in_reg.sent_total_bytes;
                if (count_reg != DEPTH_C)
                    count_next = count_reg + 1'b1;
                idx_next    = '0;
                sum_rx_next = '0;
                sum_tx_next = '0;
            end
            trapm_pkg::ST_SUM_RD:
                if (XW'(idx_reg) < eff_x)
                    idx_next = idx_reg + 1'b1;
                else
                    div_n_next = eff;
            trapm_pkg::ST_SUM_ACC:
            begin
                sum_rx_next = sum_rx_reg + SW'(rate_rx_rd_reg);
                sum_tx_next = sum_tx_reg + SW'(rate_tx_rd_reg);
            end
            trapm_pkg::ST_DIV_RX_GO:
                div_start = 1'b1;
            trapm_pkg::ST_DIV_RX_WAIT:
                if (div_done)
                    avg_rx_next = div_quotient[FW-1:0];
            trapm_pkg::ST_DIV_TX_GO:
                div_start = 1'b1;
            trapm_pkg::ST_DIV_TX_WAIT:
                if (div_done)
                    avg_tx_next = div_quotient[FW-1:0];
            trapm_pkg::ST_SM_WR:
            begin
                sm_we    = 1'b1;
                idx_next = '0;
            end
            trapm_pkg::ST_PEAK_RD:
                if (idx_reg < look)
                    idx_next = idx_reg + 1'b1;
            trapm_pkg::ST_PEAK_CMP:
            begin
                if (sm_rx_rd_reg > best_rx_reg)
                    best_rx_next = sm_rx_rd_reg;
                if (sm_tx_rd_reg > best_tx_reg)
                    best_tx_next = sm_tx_rd_reg;
            end
            trapm_pkg::ST_DONE:
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next                = 1'b1;
                    out_next.received_total_echo  = in_reg.received_total_bytes;
                    out_next.sent_total_echo      = in_reg.sent_total_bytes;
                    out_next.received_average     = avg_rx_reg;
                    out_next.sent_average         = avg_tx_reg;
                    out_next.received_peak        = best_rx_reg;
                    out_next.sent_peak            = best_tx_reg;
                    out_next.baseline_only        = base_flag_reg;
                end
            trapm_pkg::ST_RB_INIT:
            begin
                idx_next    = '0;
                rb_i_next   = '0;
                sum_rx_next = '0;
                sum_tx_next = '0;
            end
            trapm_pkg::ST_RB_ENTRY:
                div_n_next = rb_n;
            trapm_pkg::ST_RB_SUB_RD:
                idx_next = idx_reg;
            trapm_pkg::ST_RB_SUB:
            begin
                // Drop the entry that leaves the trailing window.
                sum_rx_next = sum_rx_reg - SW'(rate_rx_rd_reg);
                sum_tx_next = sum_tx_reg - SW'(rate_tx_rd_reg);
            end
            trapm_pkg::ST_RB_ADD_RD:
                rb_i_next = rb_i_reg + 1'b1;
            trapm_pkg::ST_RB_ADD:
            begin
                sum_rx_next = sum_rx_reg + SW'(rate_rx_rd_reg);
                sum_tx_next = sum_tx_reg + SW'(rate_tx_rd_reg);
            end
            default:
                idx_next = idx_reg;
        endcase

        if (cfg_change)
        begin
            window_next  = cfg_win;
            rb_mode_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= trapm_pkg::ST_IDLE;
            rb_mode_reg   <= 1'b0;
            window_reg    <= trapm_pkg::WINDOW_RESET;
            have_base_reg <= 1'b0;
            count_reg     <= '0;
            newest_reg    <= '0;
            idx_reg       <= '0;
            rb_i_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rb_mode_reg   <= rb_mode_next;
            window_reg    <= window_next;
            have_base_reg <= have_base_next;
            count_reg     <= count_next;
            newest_reg    <= newest_next;
            idx_reg       <= idx_next;
            rb_i_reg      <= rb_i_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_rx_reg   <= prev_rx_next;
        prev_tx_reg   <= prev_tx_next;
        in_reg        <= in_next;
        base_flag_reg <= base_flag_next;
        sum_rx_reg    <= sum_rx_next;
        sum_tx_reg    <= sum_tx_next;
        div_n_reg     <= div_n_next;
        avg_rx_reg    <= avg_rx_next;
        avg_tx_reg    <= avg_tx_next;
        best_rx_reg   <= best_rx_next;
        best_tx_reg   <= best_tx_next;
        out_reg       <= out_next;
    end

    // History memories, registered read at the shared slot address.
    always_ff @(posedge clk)
    begin
        if (rate_we)
        begin
            rate_rx_mem[newest_inc] <= delta_rx;
            rate_tx_mem[newest_inc] <= delta_tx;
        end
        rate_rx_rd_reg <= rate_rx_mem[rd_slot];
        rate_tx_rd_reg <= rate_tx_mem[rd_slot];
    end

    always_ff @(posedge clk)
    begin
        if (sm_we)
        begin
            sm_rx_mem[sm_wr_slot] <= avg_rx_reg;
            sm_tx_mem[sm_wr_slot] <= avg_tx_reg;
        end
        sm_rx_rd_reg <= sm_rx_mem[rd_slot];
        sm_tx_rd_reg <= sm_tx_mem[rd_slot];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`include "traffic_rate_average_peak_monitor_macros.svh"

    `TRAPM_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= DEPTH_C, "history count above depth")
    `TRAPM_ASSERT_NEXT(a_cfg_blocks, cfg_change, !in_ready, "window change did not start rebuild")
    `TRAPM_ASSERT_NEXT(a_tick_busy, in_fire && have_base_reg, !in_ready, "tick beat not held busy")

endmodule

### dv/traffic_rate_checker.sv
// ---------------------------------------------------------------------------
// Traffic rate monitor checker
// Watches the sample and result channels and the window register port,
// keeps its own moving average and peak history, and compares every result
// beat field by field with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module traffic_rate_checker
    import trapm_pkg::*;
#(
    parameter int HISTORY_DEPTH   = 4096,
    parameter int LOOKBACK_FACTOR = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  in_t              in_data,
    input  logic             out_valid,
    input  logic             out_ready,
    input  out_t             out_data,
    input  logic             cfg_wr_en,
    input  logic [WIN_W-1:0] cfg_wr_data,
    output int               errors,
    output int               pending,
    output int               results_seen
);

    int                 window_len;
    bit                 have_baseline;
    logic [TOTAL_W-1:0] last_total [2];
    logic [RATE_W-1:0]  rate_hist [2][HISTORY_DEPTH];
    logic [FIX_W-1:0]   smooth_hist [2][HISTORY_DEPTH];
    int                 hist_count;
    int                 newest;
    out_t               expected_results [$];

    function automatic int slot_at(int age);
        return (newest + HISTORY_DEPTH - (age % HISTORY_DEPTH)) % HISTORY_DEPTH;
    endfunction

    function automatic logic [RATE_W-1:0] tick_delta(logic [TOTAL_W-1:0] cur,
                                                     logic [TOTAL_W-1:0] prev);
        logic [TOTAL_W-1:0] d;
        if (cur < prev)
            return '0;
        d = cur - prev;
        return (d > RATE_MAX) ? RATE_MAX : d[RATE_W-1:0];
    endfunction

    function automatic logic [FIX_W-1:0] fixed_mean(longint unsigned sum, int n);
        longint unsigned q;
        if (n == 0)
            return '0;
        q = (sum << FRAC_W) / n;
        return q[FIX_W-1:0];
    endfunction

    function automatic int avg_span();
        return (window_len < hist_count) ? window_len : hist_count;
    endfunction

    // Redo the smoothed history as trailing averages of the kept deltas.
    function automatic void rebuild_smoothed(int ch);
        int              w;
        int              left;
        int              n;
        longint unsigned sum;
        w   = avg_span();
        sum = 0;
        for (int i = 0; i < w; i++)
            sum += rate_hist[ch][slot_at(i)];
        for (int i = 0; i < hist_count; i++)
        begin
            left = hist_count - i;
            n    = (w < left) ? w : left;
            smooth_hist[ch][slot_at(i)] = fixed_mean(sum, n);
            sum -= rate_hist[ch][slot_at(i)];
            if (i + w < hist_count)
                sum += rate_hist[ch][slot_at(i + w)];
        end
    endfunction

    function automatic out_t predict_tick(in_t d);
        out_t             r;
        int               n;
        int               look;
        longint unsigned  sum;
        logic [FIX_W-1:0] mean [2];
        logic [FIX_W-1:0] best [2];
        r = '0;
        r.received_total_echo = d.received_total_bytes;
        r.sent_total_echo     = d.sent_total_bytes;
        if (!have_baseline)
        begin
            have_baseline = 1'b1;
            last_total[0] = d.received_total_bytes;
            last_total[1] = d.sent_total_bytes;
            r.baseline_only = 1'b1;
            return r;
        end
        newest = (newest + 1) % HISTORY_DEPTH;
        rate_hist[0][newest] = tick_delta(d.received_total_bytes, last_total[0]);
        rate_hist[1][newest] = tick_delta(d.sent_total_bytes, last_total[1]);
        last_total[0] = d.received_total_bytes;
        last_total[1] = d.sent_total_bytes;
        if (hist_count < HISTORY_DEPTH)
            hist_count++;
        n    = avg_span();
        look = window_len * LOOKBACK_FACTOR;
        if (look > hist_count)
            look = hist_count;
        for (int ch = 0; ch < 2; ch++)
        begin
            sum = 0;
            for (int i = 0; i < n; i++)
                sum += rate_hist[ch][slot_at(i)];
            mean[ch] = fixed_mean(sum, n);
            smooth_hist[ch][newest] = mean[ch];
            best[ch] = '0;
            for (int i = 0; i < look; i++)
                if (smooth_hist[ch][slot_at(i)] > best[ch])
                    best[ch] = smooth_hist[ch][slot_at(i)];
        end
        r.received_average = mean[0];
        r.sent_average     = mean[1];
        r.received_peak    = best[0];
        r.sent_peak        = best[1];
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v,
                                        logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_t exp_r;
        int   v;
        if (!rst_n)
        begin
            window_len    = WINDOW_RESET;
            have_baseline = 1'b0;
            last_total[0] = '0;
            last_total[1] = '0;
            hist_count    = 0;
            newest        = 0;
            errors        = 0;
            results_seen  = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                v = cfg_wr_data;
                if (v < 1)
                    v = 1;
                if (v > HISTORY_DEPTH)
                    v = HISTORY_DEPTH;
                if (v != window_len)
                begin
                    window_len = v;
                    rebuild_smoothed(0);
                    rebuild_smoothed(1);
                end
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no sample waiting");
                    errors++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    check_field("received_total_echo", exp_r.received_total_echo,
                                out_data.received_total_echo);
                    check_field("sent_total_echo", exp_r.sent_total_echo,
                                out_data.sent_total_echo);
                    check_field("received_average", exp_r.received_average,
                                out_data.received_average);
                    check_field("sent_average", exp_r.sent_average,
                                out_data.sent_average);
                    check_field("received_peak", exp_r.received_peak,
                                out_data.received_peak);
                    check_field("sent_peak", exp_r.sent_peak, out_data.sent_peak);
                    check_field("baseline_only", exp_r.baseline_only,
                                out_data.baseline_only);
                end
            end
            if (in_valid && in_ready)
                expected_results.insert(expected_results.size(), predict_tick(in_data));
        end
        pending = expected_results.size();
    end

endmodule

### dv/tb_traffic_rate_average_peak_monitor.sv
// ---------------------------------------------------------------------------
// Traffic rate monitor testbench
// Drives byte total samples through several window lengths, including the
// clamped extremes, with random gaps and a long receiver stall; the checker
// predicts and compares every result beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_traffic_rate_average_peak_monitor;
    import trapm_pkg::*;

    localparam int HISTORY_DEPTH = 4096;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    in_t              in_data;
    logic             out_valid;
    logic             out_ready;
    out_t             out_data;
    logic             cfg_wr_en;
    logic [WIN_W-1:0] cfg_wr_data;
    int               errors;
    int               pending;
    int               results_seen;

    bit                 idle_on;
    bit                 stall_req;
    int                 samples_sent;
    logic [TOTAL_W-1:0] rx_total;
    logic [TOTAL_W-1:0] tx_total;

    traffic_rate_average_peak_monitor #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    traffic_rate_checker #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #200ms;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_req)
            begin
                out_ready <= 1'b0;
                repeat (6000) @(negedge clk);
                stall_req = 1'b0;
            end
            out_ready <= !(idle_on && $urandom_range(99) < 16);
        end
    end

    function automatic logic [TOTAL_W-1:0] random_total();
        return TOTAL_W'({$urandom, $urandom});
    endfunction

    // Advance a counter by a random step: often modest, sometimes huge,
    // sometimes a fall, no change or a fresh random value.
    function automatic logic [TOTAL_W-1:0] step_total(logic [TOTAL_W-1:0] cur);
        int pick;
        pick = $urandom_range(99);
        if (pick < 40)
            return cur + $urandom_range(0, 5000);
        else if (pick < 70)
            return cur + $urandom;
        else if (pick < 78)
            return TOTAL_W'(cur + {$urandom_range(1, 255), $urandom});
        else if (pick < 86)
            return cur - $urandom_range(1, 1000);
        else if (pick < 92)
            return cur;
        return random_total();
    endfunction

    task automatic send_sample(logic [TOTAL_W-1:0] rx, logic [TOTAL_W-1:0] tx);
        while (idle_on && $urandom_range(99) < 16)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= in_t'{rx, tx};
        rx_total = rx;
        tx_total = tx;
        do
            @(posedge clk);
        while (!in_ready);
        samples_sent++;
    endtask

    task automatic send_random(int count);
        repeat (count)
            send_sample(step_total(rx_total), step_total(tx_total));
    endtask

    // Drop valid, wait for every result, then let the block settle.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic write_window(logic [WIN_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        idle_on      = 1'b1;
        stall_req    = 1'b0;
        samples_sent = 0;
        rx_total     = '0;
        tx_total     = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: baseline, fall, saturation, extremes, window at reset value
        send_sample(63'd1000, 63'd2000);
        send_sample(63'd1500, 63'd2000);
        send_sample(63'd10, 63'd1999);
        send_sample(63'd10 + (63'd1 << 40), TOTAL_MAX);
        send_sample(TOTAL_MAX, TOTAL_MAX);
        send_sample(63'd0, 63'd0);
        send_sample(63'hFFFF_FFFF, 63'h1_0000_0000);
        send_sample(63'h1_FFFF_FFFE, 63'h1_0000_0000);
        send_sample(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
        send_sample(63'h5555_5555_5555_5555 + 63'd7, 63'h2AAA_AAAA_AAAA_AAAA + 63'd3);
        send_random(8);
        drain();

        // Largest window (8191 clamps to the history depth)
        write_window(13'h1FFF);
        send_random(60);
        drain();

        // Zero clamps to one; writing one again keeps history untouched
        write_window(13'd0);
        send_random(20);
        drain();
        write_window(13'd1);
        send_random(20);
        drain();

        // Small window, one long receiver hold-off while samples keep coming
        write_window(13'd7);
        idle_on = 1'b0;
        send_random(40);
        stall_req = 1'b1;
        send_random(60);
        idle_on = 1'b1;
        send_random(50);
        drain();

        write_window(13'd30);
        send_random(300);
        drain();

        // Short window over a long history
        write_window(13'd2);
        send_random(130);
        drain();

        $display("Sent %0d samples over windows 30, %0d, 1, 7, 2 with one long stall;",
                 samples_sent, HISTORY_DEPTH);
        $display("checked %0d result beats with %0d mismatches.", results_seen, errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/trapm_pkg.sv
src/trapm_div.sv
src/traffic_rate_average_peak_monitor.sv
dv/traffic_rate_checker.sv
dv/tb_traffic_rate_average_peak_monitor.sv
